>>> rtl/fvaos_pkg.sv
// ----------------------------------------------------------------------------
// fvaos_pkg
// Types and constants shared by the arpeggio octave shifter and its checker.
// ----------------------------------------------------------------------------
package fvaos_pkg;

    localparam int NOTE_W     = 7;   // stored note / input note and velocity
    localparam int NOTE_OUT_W = 9;   // shifted note, two's complement
    localparam int SLOT_W     = 2;   // slot field of a result item
    localparam int SHIFT_W    = 2;   // octave shift 0..3
    localparam int IN_DATA_W  = 16;  // note_number + velocity, padded to bytes
    localparam int OUT_DATA_W = 16;  // note_out + slot, padded to bytes
    localparam int NOTE_BIAS  = 24;  // two octaves up before the shift

    // operation codes carried in tuser
    localparam logic OP_NOTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // pattern step codes
    localparam logic [1:0] PAT_ROTATE  = 2'd0;
    localparam logic [1:0] PAT_PAIRS   = 2'd1;
    localparam logic [1:0] PAT_UNIFORM = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STORE,
        ST_TICK_ADV,
        ST_TICK_RUN
    } t_state;

endpackage

>>> rtl/four_voice_arp_octave_shifter.sv
// ----------------------------------------------------------------------------
// four_voice_arp_octave_shifter
// Voice slot allocator with an octave-shifting arpeggio on every tick.
// ----------------------------------------------------------------------------
// Note event: one slot compare per cycle through ST_SCAN, then the store in
//   ST_STORE; a key-up skips the store.
// Tick: counter update in ST_TICK_ADV, then one slot per cycle through the
//   shared note adder; an occupied slot waits while the result channel stalls.
// If slot 0 is held, ST_TICK_ADV and then ST_TICK_RUN lead to the first result.
// Synchronous active-low reset empties all slots and clears the counters.
module four_voice_arp_octave_shifter
    import fvaos_pkg::*;
#(
    parameter int VOICES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [6:0] note_number, [13:7] velocity
    input  logic                  s_axis_tuser,   // [0] operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [8:0] note_out, [10:9] slot
    output logic                  m_axis_tlast    // last
);

    localparam int IDX_W = $clog2(VOICES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    t_state r_state, n_state;

    logic [NOTE_W-1:0]     r_voice [VOICES];
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [NOTE_W-1:0]     r_note;
    logic                  r_release;
    logic                  r_held, n_held;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_empty_idx, n_empty_idx;
    logic [1:0]            r_rot, n_rot;
    logic [1:0]            r_pat, n_pat;
    logic                  r_out_valid, n_out_valid;
    logic [NOTE_OUT_W-1:0] r_out_note;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_last;

    logic                  w_accept;
    logic                  w_out_free;
    logic [NOTE_W-1:0]     w_cur;
    logic                  w_match;
    logic                  w_empty;
    logic [VOICES-1:0]     w_occ;
    logic [VOICES-1:0]     w_later;
    logic [SHIFT_W-1:0]    w_shift;
    logic [NOTE_OUT_W-1:0] w_shifted;
    logic                  w_clear_en;
    logic                  w_store_en;
    logic                  w_emit;
    logic                  w_advance;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // shared slot read and compare
    assign w_cur   = r_voice[r_idx];
    assign w_match = (w_cur == r_note);
    assign w_empty = (w_cur == '0);

    always_comb begin
        for (int k = 0; k < VOICES; k++) begin
            w_occ[k] = (r_voice[k] != '0);
        end
    end

    // occupied slots above the current one decide the last flag
    assign w_later = (w_occ >> r_idx) >> 1;

    // shared shift and note adder: note + 24 - 12*shift
    always_comb begin
        case (r_pat)
            PAT_ROTATE: w_shift = r_rot + SHIFT_W'(r_idx);
            PAT_PAIRS:  w_shift = r_rot + {r_idx[0], 1'b0};
            default:    w_shift = r_rot;
        endcase
    end

    assign w_shifted = NOTE_OUT_W'(w_cur) + NOTE_OUT_W'(NOTE_BIAS)
                     - NOTE_OUT_W'({w_shift, 3'b000}) - NOTE_OUT_W'({w_shift, 2'b00});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tuser == OP_TICK) ? ST_TICK_ADV : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = r_release ? ST_IDLE : ST_STORE;
                end
            end
            ST_STORE:    n_state = ST_IDLE;
            ST_TICK_ADV: n_state = ST_TICK_RUN;
            ST_TICK_RUN: begin
                if (w_advance && r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // control and datapath next values
    always_comb begin
        n_idx        = r_idx;
        n_held       = r_held;
        n_found      = r_found;
        n_empty_idx  = r_empty_idx;
        n_rot        = r_rot;
        n_pat        = r_pat;
        w_clear_en   = 1'b0;
        w_store_en   = 1'b0;
        w_emit       = 1'b0;
        w_advance    = 1'b0;
        n_out_valid  = r_out_valid && !m_axis_tready;
        case (r_state)
            ST_IDLE: begin
                n_idx   = '0;
                n_held  = 1'b0;
                n_found = 1'b0;
            end
            ST_SCAN: begin
                n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                if (r_release) begin
                    w_clear_en = w_match;
                end else begin
                    if (w_match) begin
                        n_held = 1'b1;
                    end
                    if (w_empty && !r_found) begin
                        n_found     = 1'b1;
                        n_empty_idx = r_idx;
                    end
                end
            end
            ST_STORE: begin
                w_store_en = r_found && !r_held;
            end
            ST_TICK_ADV: begin
                n_rot = r_rot + 2'd1;
                n_pat = (r_pat >= PAT_UNIFORM) ? PAT_ROTATE : r_pat + 2'd1;
                n_idx = '0;
            end
            ST_TICK_RUN: begin
                w_emit    = !w_empty && w_out_free;
                w_advance = w_empty || w_out_free;
                if (w_emit) begin
                    n_out_valid = 1'b1;
                end
                if (w_advance) begin
                    n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_held      <= 1'b0;
            r_found     <= 1'b0;
            r_rot       <= '0;
            r_pat       <= PAT_ROTATE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < VOICES; k++) begin
                r_voice[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_held      <= n_held;
            r_found     <= n_found;
            r_rot       <= n_rot;
            r_pat       <= n_pat;
            r_out_valid <= n_out_valid;
            if (w_clear_en) begin
                r_voice[r_idx] <= '0;
            end
            if (w_store_en) begin
                r_voice[r_empty_idx] <= r_note;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_empty_idx <= n_empty_idx;
        if (w_accept) begin
            r_note    <= s_axis_tdata[NOTE_W-1:0];
            r_release <= (s_axis_tdata[2*NOTE_W-1:NOTE_W] == '0);
        end
        if (w_emit) begin
            r_out_note <= w_shifted;
            r_out_slot <= SLOT_W'(r_idx);
            r_out_last <= (w_later == '0);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_slot, r_out_note});
    assign m_axis_tlast  = r_out_last;

endmodule

>>> rtl/fvaos_chk.sv
// ----------------------------------------------------------------------------
// fvaos_chk
// Port-level checks for the arpeggio octave shifter, bound to the top level.
// ----------------------------------------------------------------------------
module fvaos_chk
    import fvaos_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // input ready drops right after every accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

    // reset drops any pending result and leaves the block ready
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after reset");

    // padding bits above the slot stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:NOTE_OUT_W+SLOT_W] == '0))
        else $error("nonzero padding in result");

endmodule

bind four_voice_arp_octave_shifter fvaos_chk u_fvaos_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> sim/four_voice_arp_octave_shifter_tb.sv
// ----------------------------------------------------------------------------
// four_voice_arp_octave_shifter_tb
// Drives key-down, key-up and tick items into the octave shifter and checks
// every emitted note against an in-bench model of the voice slots, rotation
// and pattern counters. Both stream sides idle at random; one long receiver
// hold-off lets the block back up and stall its input.
// ----------------------------------------------------------------------------
module four_voice_arp_octave_shifter_tb;
    import fvaos_pkg::*;

    localparam int VOICE_COUNT = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_ITEMS = 250;

    typedef struct packed {
        logic [NOTE_OUT_W-1:0] note_out;
        logic [SLOT_W-1:0]     slot;
        logic                  last;
    } arp_note_t;

    // Slot allocator and arpeggio predictor; holds the notes each tick must emit.
    class arp_scoreboard;
        logic [NOTE_W-1:0]  voice_notes [VOICE_COUNT];
        logic [SHIFT_W-1:0] octave_shifts [VOICE_COUNT];
        logic [1:0]         rotation;
        logic [1:0]         pattern_step;
        arp_note_t          expected_notes[$];
        int                 errors;

        function new();
            foreach (voice_notes[j]) begin
                voice_notes[j]   = '0;
                octave_shifts[j] = '0;
            end
            rotation     = '0;
            pattern_step = PAT_ROTATE;
            errors       = 0;
        endfunction

        function void note_input(logic op, logic [NOTE_W-1:0] note, logic [NOTE_W-1:0] vel);
            bit        held;
            int        last_idx;
            int        v;
            logic [2:0] s;
            arp_note_t n;
            held     = 0;
            last_idx = -1;
            if (op == OP_NOTE) begin
                if (vel == 0) begin
                    foreach (voice_notes[j])
                        if (voice_notes[j] == note) voice_notes[j] = '0;
                    return;
                end
                foreach (voice_notes[j])
                    if (voice_notes[j] == note) held = 1;
                if (held) return;
                // note 0 matches an empty slot above, so it is never stored
                for (int j = 0; j < VOICE_COUNT; j++) begin
                    if (voice_notes[j] == 0) begin
                        voice_notes[j] = note;
                        return;
                    end
                end
                return;
            end
            rotation     = rotation + 2'd1;
            pattern_step = (pattern_step >= PAT_UNIFORM) ? PAT_ROTATE : pattern_step + 2'd1;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                case (pattern_step)
                    PAT_ROTATE: s = rotation + 3'(i);
                    PAT_PAIRS:  s = rotation + 3'(2 * (i & 1));
                    default:    s = {1'b0, rotation};
                endcase
                octave_shifts[i] = s[1:0];
            end
            for (int i = 0; i < VOICE_COUNT; i++) begin
                if (voice_notes[i] != 0) begin
                    v          = int'(voice_notes[i]) + NOTE_BIAS - 12 * int'(octave_shifts[i]);
                    n.note_out = NOTE_OUT_W'(v);
                    n.slot     = SLOT_W'(i);
                    n.last     = 1'b0;
                    expected_notes.push_back(n);
                    last_idx   = expected_notes.size() - 1;
                end
            end
            if (last_idx >= 0) expected_notes[last_idx].last = 1'b1;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            arp_note_t exp_note;
            if (expected_notes.size() == 0) begin
                $error("unexpected result: note_out=%0d slot=%0d last=%0b",
                       $signed(data[8:0]), data[10:9], last);
                errors++;
                return;
            end
            exp_note = expected_notes.pop_front();
            if (data[8:0] !== exp_note.note_out) begin
                $error("note_out: expected %0d, got %0d",
                       $signed(exp_note.note_out), $signed(data[8:0]));
                errors++;
            end
            if (data[10:9] !== exp_note.slot) begin
                $error("slot: expected %0d, got %0d", exp_note.slot, data[10:9]);
                errors++;
            end
            if (last !== exp_note.last) begin
                $error("last: expected %0b, got %0b", exp_note.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [6:0] note_number, [13:7] velocity
    logic                  s_axis_tuser;   // [0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [8:0] note_out, [10:9] slot
    logic                  m_axis_tlast;

    arp_scoreboard sb;
    int            cycles;
    int            max_gap;
    int            max_stall;
    bit            hold_off_req;

    four_voice_arp_octave_shifter #(
        .VOICES(VOICE_COUNT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Result side: random stall per item, plus one long hold-off on request.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = $urandom_range(0, max_stall);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // tvalid stays high across back-to-back items; lowered only for a gap
    task automatic send_item(input logic op, input logic [NOTE_W-1:0] note,
                             input logic [NOTE_W-1:0] vel);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, vel, note};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, note, vel);
    endtask

    task automatic key(input logic [NOTE_W-1:0] note, input logic [NOTE_W-1:0] vel);
        send_item(OP_NOTE, note, vel);
    endtask

    task automatic tick();
        send_item(OP_TICK, NOTE_W'($urandom), NOTE_W'($urandom));
    endtask

    task automatic random_item();
        int r;
        logic [NOTE_W-1:0] note;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            tick();
        end else if (r < 70) begin
            if (r < 42)
                note = sb.voice_notes[$urandom_range(0, VOICE_COUNT - 1)];
            else if ($urandom_range(0, 24) == 0)
                note = '0;
            else
                note = NOTE_W'($urandom_range(1, 127));
            key(note, NOTE_W'($urandom_range(1, 127)));
        end else if (r < 93) begin
            key(sb.voice_notes[$urandom_range(0, VOICE_COUNT - 1)], '0);
        end else begin
            key(NOTE_W'($urandom_range(0, 127)), '0);
        end
    endtask

    initial begin
        sb            = new();
        cycles        = 0;
        max_gap       = 4;
        max_stall     = 4;
        hold_off_req  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NOTE;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty slots: tick emits nothing, note 0 is never stored
        tick();
        key(7'd0, 7'd127);
        key(7'd0, 7'd0);
        tick();
        key(7'd127, 7'd127);
        key(7'd1, 7'd1);
        key(7'd60, 7'd64);
        key(7'd60, 7'd100);     // already held
        key(7'd85, 7'd42);
        key(7'd42, 7'd90);      // all slots full, dropped
        tick();
        tick();
        tick();
        tick();
        key(7'd60, 7'd0);
        key(7'd99, 7'd0);       // release of a note not held
        tick();
        key(7'd42, 7'd90);      // fills the freed slot
        key(7'd127, 7'd0);
        tick();
        tick();
        key(7'd1, 7'd0);
        key(7'd85, 7'd0);
        key(7'd42, 7'd0);
        tick();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 4;
                max_stall = ($urandom_range(0, 3) == 0) ? 0 : 4;
            end
            if (n == 100) begin
                hold_off_req = 1;
                max_gap      = 0;
            end
            random_item();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_notes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_notes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.expected_notes.size() != 0)
                $error("%0d expected results never arrived", sb.expected_notes.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> four_voice_arp_octave_shifter.f
rtl/fvaos_pkg.sv
rtl/four_voice_arp_octave_shifter.sv
rtl/fvaos_chk.sv
sim/four_voice_arp_octave_shifter_tb.sv
